[hw/rtl/sblp_pkg.sv]
// Shared types and constants for the serial boot loader protocol block.
// No dependencies; imported by the engine, the result buffer and the top level.
package sblp_pkg;

  localparam logic [1:0] KIND_TX    = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_JUMP  = 2'd2;

  localparam logic [7:0] CMD_LOAD = 8'h73;
  localparam logic [7:0] CMD_JUMP = 8'h6A;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [31:0] write_addr;
    logic [7:0]  write_data;
    logic [31:0] jump_addr;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } step_res_t;

endpackage

[hw/rtl/sblp_in_reg.sv]
// Input register stage: holds one received byte until the engine takes it.
// Depends on nothing outside this file.
module sblp_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       take,
  output logic       q_valid,
  output logic [7:0] q_byte
);

  assign in_ready = !q_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      q_valid <= 1'b1;
    end else if (take) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_byte <= rx_byte;
    end
  end

endmodule

[hw/rtl/sblp_engine.sv]
// Protocol engine: phase, word assembly, load counters and sum; one byte per step.
// Uses sblp_pkg for result types, kind codes and command bytes.
module sblp_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  output sblp_pkg::step_res_t step_res
);
  import sblp_pkg::*;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_S_LEN  = 3'd1;
  localparam logic [2:0] PH_S_ADDR = 3'd2;
  localparam logic [2:0] PH_S_DATA = 3'd3;
  localparam logic [2:0] PH_S_CHK  = 3'd4;
  localparam logic [2:0] PH_J_ADDR = 3'd5;

  logic [2:0]  phase, phase_next;
  logic [1:0]  word_byte_count, word_byte_count_next;
  logic [31:0] word_shift, word_shift_next;
  logic [31:0] load_length, load_length_next;
  logic [31:0] load_address, load_address_next;
  logic [31:0] bytes_done, bytes_done_next;
  logic [31:0] running_sum, running_sum_next;

  logic [31:0] shifted;
  logic        word_done;
  logic [1:0]  count_adv;
  logic [31:0] done_inc;

  assign shifted   = {word_shift[23:0], rx_byte};
  assign word_done = (word_byte_count == 2'd3);
  assign count_adv = word_done ? 2'd0 : word_byte_count + 2'd1;
  assign done_inc  = bytes_done + 32'd1;

  always_comb begin
    phase_next           = phase;
    word_byte_count_next = word_byte_count;
    word_shift_next      = word_shift;
    load_length_next     = load_length;
    load_address_next    = load_address;
    bytes_done_next      = bytes_done;
    running_sum_next     = running_sum;
    step_res             = '0;
    case (phase)
      PH_S_LEN: begin
        word_shift_next      = shifted;
        word_byte_count_next = count_adv;
        if (word_done) begin
          load_length_next = shifted;
          phase_next       = PH_S_ADDR;
        end
      end
      PH_S_ADDR: begin
        word_shift_next      = shifted;
        word_byte_count_next = count_adv;
        if (word_done) begin
          load_address_next = shifted;
          bytes_done_next   = '0;
          if (!load_length[31] && (load_length != 32'd0)) begin
            phase_next = PH_S_DATA;
          end else begin
            phase_next = PH_S_CHK;
          end
        end
      end
      PH_S_DATA: begin
        step_res.valid          = 1'b1;
        step_res.res.kind       = KIND_WRITE;
        step_res.res.write_addr = load_address + bytes_done;
        step_res.res.write_data = rx_byte;
        running_sum_next        = running_sum + {24'd0, rx_byte};
        bytes_done_next         = done_inc;
        if (done_inc == load_length) begin
          phase_next = PH_S_CHK;
        end
      end
      PH_S_CHK: begin
        word_shift_next      = shifted;
        word_byte_count_next = count_adv;
        if (word_done) begin
          step_res.valid       = 1'b1;
          step_res.res.kind    = KIND_TX;
          step_res.res.tx_byte = {7'd0, shifted != running_sum};
          phase_next           = PH_IDLE;
        end
      end
      PH_J_ADDR: begin
        word_shift_next      = shifted;
        word_byte_count_next = count_adv;
        if (word_done) begin
          step_res.valid         = 1'b1;
          step_res.res.kind      = KIND_JUMP;
          step_res.res.jump_addr = shifted;
          phase_next             = PH_IDLE;
        end
      end
      default: begin
        phase_next           = PH_IDLE;
        word_byte_count_next = 2'd0;
        if (rx_byte == CMD_LOAD) begin
          running_sum_next     = '0;
          bytes_done_next      = '0;
          phase_next           = PH_S_LEN;
          step_res.valid       = 1'b1;
          step_res.res.kind    = KIND_TX;
          step_res.res.tx_byte = CMD_LOAD;
        end else if (rx_byte == CMD_JUMP) begin
          phase_next           = PH_J_ADDR;
          step_res.valid       = 1'b1;
          step_res.res.kind    = KIND_TX;
          step_res.res.tx_byte = CMD_JUMP;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      word_byte_count <= 2'd0;
      word_shift      <= '0;
      load_length     <= '0;
      load_address    <= '0;
      bytes_done      <= '0;
      running_sum     <= '0;
    end else if (step) begin
      phase           <= phase_next;
      word_byte_count <= word_byte_count_next;
      word_shift      <= word_shift_next;
      load_length     <= load_length_next;
      load_address    <= load_address_next;
      bytes_done      <= bytes_done_next;
      running_sum     <= running_sum_next;
    end
  end

endmodule

[hw/rtl/sblp_out_buf.sv]
// Two-entry result buffer: registers engine results and decouples output stalls.
// Uses sblp_pkg for the result type.
module sblp_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sblp_pkg::res_t      push_data,
  output logic                has_space,
  output logic                out_valid,
  input  logic                out_ready,
  output sblp_pkg::res_t      out_data
);
  import sblp_pkg::*;

  res_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign has_space = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

[hw/rtl/serial_boot_loader_protocol.sv]
// Serial boot loader protocol: top level; input register, engine, result buffer.
// Each byte is held in the input register and its result in the result buffer; 1 byte per cycle while it has room.
// The engine takes one registered byte per cycle while the two-entry buffer has room.
// Synchronous reset returns to idle awaiting a command with all counters and sum zero.
// Depends on sblp_pkg, sblp_in_reg, sblp_engine and sblp_out_buf.
module serial_boot_loader_protocol (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  tx_byte,
  output logic [31:0] write_addr,
  output logic [7:0]  write_data,
  output logic [31:0] jump_addr
);
  import sblp_pkg::*;

  logic      q_valid;
  logic [7:0] q_byte;
  logic      has_space;
  logic      step;
  step_res_t step_res;
  res_t      out_data;

  assign step = q_valid && has_space;

  sblp_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .take     (step),
    .q_valid  (q_valid),
    .q_byte   (q_byte)
  );

  sblp_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .rx_byte  (q_byte),
    .step_res (step_res)
  );

  sblp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (step && step_res.valid),
    .push_data (step_res.res),
    .has_space (has_space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_kind   = out_data.kind;
  assign tx_byte    = out_data.tx_byte;
  assign write_addr = out_data.write_addr;
  assign write_data = out_data.write_data;
  assign jump_addr  = out_data.jump_addr;

`ifndef SYNTHESIS
  a_in_captured: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> q_valid)
    else $error("accepted item not held in input register");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_kind == KIND_TX || out_kind == KIND_WRITE || out_kind == KIND_JUMP))
    else $error("illegal result kind");

  a_tx_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == KIND_TX) |-> (write_addr == 32'd0 && jump_addr == 32'd0))
    else $error("transmit result carries stray address");

  a_stall_blocks_step: assert property (@(posedge clk) disable iff (rst)
    !has_space |-> !step)
    else $error("engine stepped with result buffer full");
`endif

endmodule

[tb/sblp_checker.sv]
// Checker for the serial boot loader protocol block: watches both streams, predicts
// each result from the accepted bytes and compares it field by field.
// Depends on sblp_pkg for the result struct, kind codes and command bytes.
module sblp_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_kind,
  input  logic [7:0]  tx_byte,
  input  logic [31:0] write_addr,
  input  logic [7:0]  write_data,
  input  logic [31:0] jump_addr,
  output int          fail_count,
  output int          pending
);
  import sblp_pkg::*;

  typedef enum logic [2:0] {
    LD_IDLE,
    LD_LEN,
    LD_ADDR,
    LD_DATA,
    LD_CHK,
    LD_JADDR
  } loader_phase_e;

  loader_phase_e phase;
  logic [1:0]    word_cnt;
  logic [31:0]   word_sr;
  logic [31:0]   load_len;
  logic [31:0]   load_base;
  logic [31:0]   data_cnt;
  logic [31:0]   data_sum;
  res_t          expected_q[$];

  // big-endian word assembly; true on the fourth byte
  function automatic bit word_done(input logic [7:0] b);
    word_sr = {word_sr[23:0], b};
    if (word_cnt == 2'd3) begin
      word_cnt = 2'd0;
      return 1'b1;
    end
    word_cnt = word_cnt + 2'd1;
    return 1'b0;
  endfunction

  function automatic bit loader_step(input logic [7:0] b, output res_t r);
    r = '0;
    case (phase)
      LD_LEN: begin
        if (word_done(b)) begin
          load_len = word_sr;
          phase = LD_ADDR;
        end
      end
      LD_ADDR: begin
        if (word_done(b)) begin
          load_base = word_sr;
          data_cnt = '0;
          if (!load_len[31] && load_len != 32'd0) phase = LD_DATA;
          else phase = LD_CHK;
        end
      end
      LD_DATA: begin
        r.kind = KIND_WRITE;
        r.write_addr = load_base + data_cnt;
        r.write_data = b;
        data_sum = data_sum + {24'd0, b};
        data_cnt = data_cnt + 32'd1;
        if (data_cnt == load_len) phase = LD_CHK;
        return 1'b1;
      end
      LD_CHK: begin
        if (word_done(b)) begin
          r.kind = KIND_TX;
          r.tx_byte = (word_sr != data_sum) ? 8'd1 : 8'd0;
          phase = LD_IDLE;
          return 1'b1;
        end
      end
      LD_JADDR: begin
        if (word_done(b)) begin
          r.kind = KIND_JUMP;
          r.jump_addr = word_sr;
          phase = LD_IDLE;
          return 1'b1;
        end
      end
      default: begin
        phase = LD_IDLE;
        word_cnt = 2'd0;
        if (b == CMD_LOAD) begin
          data_sum = '0;
          data_cnt = '0;
          phase = LD_LEN;
          r.kind = KIND_TX;
          r.tx_byte = CMD_LOAD;
          return 1'b1;
        end
        if (b == CMD_JUMP) begin
          phase = LD_JADDR;
          r.kind = KIND_TX;
          r.tx_byte = CMD_JUMP;
          return 1'b1;
        end
      end
    endcase
    return 1'b0;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    res_t want_r;
    res_t next_r;
    if (rst) begin
      phase = LD_IDLE;
      word_cnt = '0;
      word_sr = '0;
      load_len = '0;
      load_base = '0;
      data_cnt = '0;
      data_sum = '0;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result item: kind %0d", out_kind);
          fail_count++;
        end else begin
          want_r = expected_q.pop_front();
          check_field("out_kind", 32'(want_r.kind), 32'(out_kind));
          check_field("tx_byte", 32'(want_r.tx_byte), 32'(tx_byte));
          check_field("write_addr", want_r.write_addr, write_addr);
          check_field("write_data", 32'(want_r.write_data), 32'(write_data));
          check_field("jump_addr", want_r.jump_addr, jump_addr);
        end
      end
      if (in_valid && in_ready) begin
        if (loader_step(rx_byte, next_r)) expected_q.push_back(next_r);
      end
    end
    pending = expected_q.size();
  end

endmodule

[tb/tb_serial_boot_loader_protocol.sv]
// Testbench top for serial_boot_loader_protocol: drives load and jump frames plus
// stray bytes with random gaps and stalls; sblp_checker predicts and compares.
// Depends on sblp_pkg, sblp_checker and the block's RTL.
module tb_serial_boot_loader_protocol;
  import sblp_pkg::*;

  localparam int RUN_ITEMS   = 750;
  localparam int QUIET_FROM  = 630;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [7:0]  rx_byte = 8'd0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [7:0]  tx_byte;
  logic [31:0] write_addr;
  logic [7:0]  write_data;
  logic [31:0] jump_addr;
  int          fail_count;
  int          pending;

  int cycles = 0;
  int gap_pct = 0;
  int stall_left = 0;
  bit quiet = 1'b0;
  int n_bytes = 0;
  int n_stray = 0;
  int n_loads = 0;
  int n_bad_sums = 0;
  int n_jumps = 0;

  serial_boot_loader_protocol u_dut (.*);
  sblp_checker u_checker (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("serial_boot_loader_protocol: mismatch");
      $finish;
    end
  end

  // result side back-pressure in bursts of random length
  always @(negedge clk) begin
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < gap_pct) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 18);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    n_bytes++;
  endtask

  task automatic send_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) send_byte(w[8*i +: 8]);
  endtask

  task automatic load_frame(input logic [31:0] len, input logic [31:0] base,
                            input bit good_sum);
    logic [31:0] sum;
    logic [7:0]  d;
    int          n;
    sum = '0;
    n = (len[31] || len == 32'd0) ? 0 : int'(len);
    send_byte(CMD_LOAD);
    send_word(len);
    send_word(base);
    for (int i = 0; i < n; i++) begin
      d = 8'($urandom_range(0, 255));
      sum = sum + {24'd0, d};
      send_byte(d);
    end
    if (good_sum) begin
      send_word(sum);
    end else begin
      send_word(($urandom_range(0, 1) == 0) ? sum ^ (32'd1 << $urandom_range(0, 31))
                                             : 32'($urandom));
      n_bad_sums++;
    end
    n_loads++;
  endtask

  task automatic jump_frame(input logic [31:0] target);
    send_byte(CMD_JUMP);
    send_word(target);
    n_jumps++;
  endtask

  task automatic stray_byte(input logic [7:0] b);
    send_byte(b);
    n_stray++;
  endtask

  initial begin
    int          pick;
    int          frames;
    logic [31:0] len;
    logic [31:0] base;
    logic [7:0]  junk;
    frames = 0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    stray_byte(8'h00);
    stray_byte(8'hFF);
    jump_frame(32'hFFFF_FFFF);
    load_frame(32'd2, 32'hFFFF_FFFF, 1'b1);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);

    while (n_bytes - n_stray < RUN_ITEMS) begin
      if (frames % 25 == 0) begin
        case ($urandom_range(0, 3))
          0: gap_pct = 0;
          1: gap_pct = 5;
          2: gap_pct = 20;
          default: gap_pct = 50;
        endcase
      end
      quiet = (n_bytes - n_stray) > QUIET_FROM;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        case ($urandom_range(0, 15))
          0: len = 32'd0;
          1: len = {1'b1, 31'($urandom)};
          2: len = 32'hFFFF_FFFF;
          3: len = 32'($urandom_range(17, 40));
          default: len = 32'($urandom_range(1, 8));
        endcase
        if ($urandom_range(0, 3) == 0) base = 32'hFFFF_FFFF - 32'($urandom_range(0, 6));
        else base = 32'($urandom);
        load_frame(len, base, $urandom_range(0, 1) == 1);
      end else if (pick < 80) begin
        case ($urandom_range(0, 5))
          0: jump_frame(32'd0);
          1: jump_frame(32'hFFFF_FFFF);
          default: jump_frame(32'($urandom));
        endcase
      end else begin
        junk = 8'($urandom_range(0, 255));
        if (junk == CMD_LOAD || junk == CMD_JUMP) junk = junk ^ 8'h01;
        stray_byte(junk);
      end
      if ($urandom_range(0, 29) == 0) begin
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
      end
      frames++;
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Sent %0d bytes: %0d load frames (%0d with a wrong checksum), %0d jumps,",
             n_bytes, n_loads, n_bad_sums, n_jumps);
    $display("and %0d stray command bytes, with random gaps and stalls on both sides.",
             n_stray);
    if (fail_count == 0) begin
      $display("serial_boot_loader_protocol: match");
    end else begin
      $display("serial_boot_loader_protocol: mismatch");
    end
    $finish;
  end

endmodule
